@@ hw/rtl/axr_pkg.sv @@
// Shared constants, widths and the CORDIC angle table for the axis-angle
// rotation matrix pipeline. No dependencies.
`timescale 1ns / 1ps

package axr_pkg;

  localparam int unsigned TDATA_IN_W  = 64;
  localparam int unsigned TDATA_OUT_W = 144;

  // square root: 60-bit radicand, one result bit per stage
  localparam int unsigned SQ_IN_W    = 60;
  localparam int unsigned SQ_RES_W   = 61;
  localparam int unsigned SQ_OUT_W   = 31;
  localparam int unsigned SQRT_STEPS = 31;

  // restoring divider: one quotient bit per stage
  localparam int unsigned DIV_NUM_W = 62;
  localparam int unsigned DIV_DEN_W = 48;
  localparam int unsigned DIV_Q_W   = 31;
  localparam int unsigned DIV_STEPS = 31;

  // CORDIC, Q.30
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CW           = 34;
  localparam int unsigned HW           = 35;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [HW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [HW-1:0] PIH_Q30     = 35'sd1686629713;

  // quaternion (Q.22) and product widths
  localparam int unsigned QW = 26;
  localparam int unsigned PW = 52;

  localparam logic [15:0] ONE_Q14 = 16'd16384;
  localparam int unsigned NUM_ENTRIES = 9;

  function automatic logic signed [HW-1:0] atan_q30(input logic [4:0] i);
    logic signed [HW-1:0] t;
    case (i)
      5'd0:    t = 35'sd843314857;
      5'd1:    t = 35'sd497837829;
      5'd2:    t = 35'sd263043837;
      5'd3:    t = 35'sd133525159;
      5'd4:    t = 35'sd67021687;
      5'd5:    t = 35'sd33543516;
      5'd6:    t = 35'sd16775851;
      5'd7:    t = 35'sd8388437;
      5'd8:    t = 35'sd4194283;
      5'd9:    t = 35'sd2097149;
      default: t = 35'sd1 <<< (5'd30 - i);
    endcase
    return t;
  endfunction

endpackage

@@ hw/rtl/axis_angle_rotation_matrix.sv @@
// Axis-angle to 3x3 rotation matrix via a unit quaternion, Q4.12 in, Q1.14 out.
// Throughput one transaction per cycle when not stalled. Depth is set by the
// 31-stage square root, the 31-stage axis divider and the 31-stage entry dividers.
// The whole pipeline holds while the output register waits on m_axis_tready.
// rst_ni clears the valid bits only; payload registers are not reset.
// Depends on axr_pkg, axr_sqrt, axr_cordic, axr_div.
`timescale 1ns / 1ps

module axis_angle_rotation_matrix (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // angle [15:0], axis_x [31:16], axis_y [47:32], axis_z [63:48]
  input  logic [axr_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // m00 [15:0], m01, m02, m10, m11, m12, m20, m21, m22 [143:128]
  output logic [axr_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
  // zero_axis [0]
  output logic [0:0]                       m_axis_tuser
);
  import axr_pkg::*;

  localparam int unsigned LAT = 2 + SQRT_STEPS + DIV_STEPS + 4 + DIV_STEPS + 1;

  typedef struct packed {
    logic [2:0] neg;
    logic [15:0] mx, my, mz;
    logic        zero;
  } axis_sb_t;

  typedef struct packed {
    logic signed [CW-1:0] cx, cy;
    logic [2:0]           neg;
    logic                 zero;
  } quat_sb_t;

  typedef struct packed {
    logic [NUM_ENTRIES-1:0] neg;
    logic                   zero;
    logic                   n2zero;
  } ent_sb_t;

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // ---- stage 1: squares, half-angle reduction
  logic signed [15:0]   ang, ax, ay, az;
  logic signed [HW-1:0] h_raw, h_d;
  logic [31:0]          sqx_q, sqy_q, sqz_q;
  logic signed [HW-1:0] h1_q;
  logic signed [15:0]   ax1_q, ay1_q, az1_q;

  assign ang   = s_axis_tdata[15:0];
  assign ax    = s_axis_tdata[31:16];
  assign ay    = s_axis_tdata[47:32];
  assign az    = s_axis_tdata[63:48];
  assign h_raw = {{2{ang[15]}}, ang, 17'b0};

  always_comb begin
    if (h_raw > PIH_Q30) begin
      h_d = h_raw - PI_Q30;
    end else if (h_raw < -PIH_Q30) begin
      h_d = h_raw + PI_Q30;
    end else begin
      h_d = h_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= ax * ax;
      sqy_q <= ay * ay;
      sqz_q <= az * az;
      h1_q  <= h_d;
      ax1_q <= ax;
      ay1_q <= ay;
      az1_q <= az;
    end
  end

  // ---- stage 2: squared length
  logic [31:0]          len2;
  logic [SQ_IN_W-1:0]   rad_q;
  logic signed [HW-1:0] h2_q;
  axis_sb_t             sb1_d;
  axis_sb_t             sb1_in_q;

  assign len2 = sqx_q + sqy_q + sqz_q;

  always_comb begin
    sb1_d.neg  = {az1_q[15], ay1_q[15], ax1_q[15]};
    sb1_d.mx   = ax1_q[15] ? 16'(-ax1_q) : ax1_q;
    sb1_d.my   = ay1_q[15] ? 16'(-ay1_q) : ay1_q;
    sb1_d.mz   = az1_q[15] ? 16'(-az1_q) : az1_q;
    sb1_d.zero = (len2 == 32'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q    <= {len2, 28'b0};
      h2_q     <= h1_q;
      sb1_in_q <= sb1_d;
    end
  end

  // ---- square root and CORDIC side by side
  logic [SQ_OUT_W-1:0]  root;
  logic signed [CW-1:0] cos_v, sin_v;
  axis_sb_t             sb1_q [SQRT_STEPS];

  axr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (root)
  );

  axr_cordic u_cordic (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (h2_q),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb1_q[0] <= sb1_in_q;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sb1_q[k] <= sb1_q[k-1];
      end
    end
  end

  // ---- unit axis: |comp| * 2^44 / r, rounded
  axis_sb_t             sb1_o;
  logic [DIV_NUM_W-1:0] unum_x, unum_y, unum_z, rhalf;
  logic [DIV_Q_W-1:0]   ux_mag, uy_mag, uz_mag;
  quat_sb_t             sb2_d;
  quat_sb_t             sb2_q [DIV_STEPS];

  assign sb1_o  = sb1_q[SQRT_STEPS-1];
  assign rhalf  = DIV_NUM_W'(root >> 1);
  assign unum_x = {2'b00, sb1_o.mx, 44'b0} + rhalf;
  assign unum_y = {2'b00, sb1_o.my, 44'b0} + rhalf;
  assign unum_z = {2'b00, sb1_o.mz, 44'b0} + rhalf;

  axr_div u_div_x (.clk_i(clk_i), .en_i(en), .num_i(unum_x),
                   .den_i(DIV_DEN_W'(root)), .quo_o(ux_mag));
  axr_div u_div_y (.clk_i(clk_i), .en_i(en), .num_i(unum_y),
                   .den_i(DIV_DEN_W'(root)), .quo_o(uy_mag));
  axr_div u_div_z (.clk_i(clk_i), .en_i(en), .num_i(unum_z),
                   .den_i(DIV_DEN_W'(root)), .quo_o(uz_mag));

  always_comb begin
    sb2_d.cx   = cos_v;
    sb2_d.cy   = sin_v;
    sb2_d.neg  = sb1_o.neg;
    sb2_d.zero = sb1_o.zero;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb2_q[0] <= sb2_d;
      for (int k = 1; k < DIV_STEPS; k++) begin
        sb2_q[k] <= sb2_q[k-1];
      end
    end
  end

  // ---- Q1: sin * unit axis, cos rounding
  quat_sb_t             sb2_o;
  logic signed [31:0]   ux, uy, uz;
  logic signed [CW-1:0] cx_rnd;
  logic signed [65:0]   pb_q, pc_q, pd_q;
  logic signed [QW-1:0] a1_q;
  logic                 zero_q1;

  assign sb2_o  = sb2_q[DIV_STEPS-1];
  assign ux     = sb2_o.neg[0] ? -signed'({1'b0, ux_mag}) : signed'({1'b0, ux_mag});
  assign uy     = sb2_o.neg[1] ? -signed'({1'b0, uy_mag}) : signed'({1'b0, uy_mag});
  assign uz     = sb2_o.neg[2] ? -signed'({1'b0, uz_mag}) : signed'({1'b0, uz_mag});
  assign cx_rnd = (sb2_o.cx + 34'sd128) >>> 8;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pb_q    <= sb2_o.cy * ux;
      pc_q    <= sb2_o.cy * uy;
      pd_q    <= sb2_o.cy * uz;
      a1_q    <= cx_rnd[QW-1:0];
      zero_q1 <= sb2_o.zero;
    end
  end

  // ---- Q2: round products to Q.22
  localparam logic signed [65:0] RND38 = 66'sd1 <<< 37;
  logic signed [65:0]   pb_r, pc_r, pd_r;
  logic signed [QW-1:0] a_q, b_q, c_q, d_q;
  logic                 zero_q2;

  assign pb_r = (pb_q + RND38) >>> 38;
  assign pc_r = (pc_q + RND38) >>> 38;
  assign pd_r = (pd_q + RND38) >>> 38;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q     <= a1_q;
      b_q     <= pb_r[QW-1:0];
      c_q     <= pc_r[QW-1:0];
      d_q     <= pd_r[QW-1:0];
      zero_q2 <= zero_q1;
    end
  end

  // ---- P: quaternion products
  logic signed [PW-1:0] aa_q, bb_q, cc_q, dd_q, bc_q, da_q, bd_q, ca_q, cd_q, ba_q;
  logic                 zero_q3;

  always_ff @(posedge clk_i) begin
    if (en) begin
      aa_q    <= a_q * a_q;
      bb_q    <= b_q * b_q;
      cc_q    <= c_q * c_q;
      dd_q    <= d_q * d_q;
      bc_q    <= b_q * c_q;
      da_q    <= d_q * a_q;
      bd_q    <= b_q * d_q;
      ca_q    <= c_q * a_q;
      cd_q    <= c_q * d_q;
      ba_q    <= b_q * a_q;
      zero_q3 <= zero_q2;
    end
  end

  // ---- N: norm and numerators
  logic signed [PW-1:0] n2;
  logic signed [PW-1:0] ent_num [NUM_ENTRIES];
  logic [DIV_DEN_W-1:0] mag_q [NUM_ENTRIES];
  logic [DIV_DEN_W-1:0] n2_q;
  ent_sb_t              sb3_in_q;

  assign n2 = aa_q + bb_q + cc_q + dd_q;

  always_comb begin
    ent_num[0] = n2 - ((cc_q + dd_q) <<< 1);
    ent_num[1] = (bc_q - da_q) <<< 1;
    ent_num[2] = (bd_q + ca_q) <<< 1;
    ent_num[3] = (bc_q + da_q) <<< 1;
    ent_num[4] = n2 - ((bb_q + dd_q) <<< 1);
    ent_num[5] = (cd_q - ba_q) <<< 1;
    ent_num[6] = (bd_q - ca_q) <<< 1;
    ent_num[7] = (cd_q + ba_q) <<< 1;
    ent_num[8] = n2 - ((bb_q + cc_q) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        mag_q[k] <= ent_num[k][PW-1] ? DIV_DEN_W'(-ent_num[k]) : DIV_DEN_W'(ent_num[k]);
        sb3_in_q.neg[k] <= ent_num[k][PW-1];
      end
      n2_q            <= DIV_DEN_W'(n2);
      sb3_in_q.zero   <= zero_q3;
      sb3_in_q.n2zero <= (n2 == '0);
    end
  end

  // ---- entry dividers: num * 2^14 / n2, rounded
  logic [DIV_Q_W-1:0] quo [NUM_ENTRIES];
  ent_sb_t            sb3_q [DIV_STEPS];

  for (genvar e = 0; e < NUM_ENTRIES; e++) begin : g_ent
    logic [DIV_NUM_W-1:0] num;
    assign num = {mag_q[e], 14'b0} + DIV_NUM_W'(n2_q >> 1);
    axr_div u_div (.clk_i(clk_i), .en_i(en), .num_i(num), .den_i(n2_q),
                   .quo_o(quo[e]));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb3_q[0] <= sb3_in_q;
      for (int k = 1; k < DIV_STEPS; k++) begin
        sb3_q[k] <= sb3_q[k-1];
      end
    end
  end

  // ---- output register: sign, saturation, identity override
  function automatic logic [15:0] sat_entry(input logic [DIV_Q_W-1:0] q, input logic neg);
    logic [16:0]        qs;
    logic signed [17:0] v;
    qs = (q > DIV_Q_W'(32768)) ? 17'd32768 : q[16:0];
    v  = neg ? -signed'({1'b0, qs}) : signed'({1'b0, qs});
    if (v > 18'sd32767) begin
      v = 18'sd32767;
    end
    return v[15:0];
  endfunction

  ent_sb_t                sb3_o;
  logic [TDATA_OUT_W-1:0] out_d, out_q;
  logic                   flag_q;

  assign sb3_o = sb3_q[DIV_STEPS-1];

  always_comb begin
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      if (sb3_o.zero || sb3_o.n2zero) begin
        out_d[16*k +: 16] = (k % 4 == 0) ? ONE_Q14 : 16'd0;
      end else begin
        out_d[16*k +: 16] = sat_entry(quo[k], sb3_o.neg[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q  <= out_d;
      flag_q <= sb3_o.zero;
    end
  end

  assign m_axis_tdata    = out_q;
  assign m_axis_tuser[0] = flag_q;

  // ---- assertions
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted transaction did not enter stage 1");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline occupancy changed during stall");

  a_zero_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[15:0] == ONE_Q14 && m_axis_tdata[79:64] == ONE_Q14 &&
      m_axis_tdata[143:128] == ONE_Q14 && m_axis_tdata[31:16] == 16'd0)
    else $error("zero axis without identity matrix");

  a_entry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
                      $signed(m_axis_tdata[15:0]) >= -16'sd16384)
    else $error("m00 outside unit range");

endmodule

@@ hw/rtl/axr_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Depends on axr_pkg.
`timescale 1ns / 1ps

module axr_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [axr_pkg::SQ_IN_W-1:0]  rad_i,
  output logic [axr_pkg::SQ_OUT_W-1:0] root_o
);
  import axr_pkg::*;

  logic [SQ_IN_W-1:0]  n_q   [SQRT_STEPS];
  logic [SQ_RES_W-1:0] res_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [SQ_RES_W:0] BIT = (SQ_RES_W + 1)'(1) << (SQ_IN_W - 2 * k);
    logic [SQ_IN_W-1:0]  n_in;
    logic [SQ_RES_W-1:0] res_in;
    logic [SQ_RES_W:0]   sum;
    logic                ge;

    if (k == 0) begin : g_first
      assign n_in   = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign n_in   = n_q[k-1];
      assign res_in = res_q[k-1];
    end

    assign sum = {1'b0, res_in} + BIT;
    assign ge  = {2'b00, n_in} >= sum;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]   <= ge ? SQ_IN_W'({2'b00, n_in} - sum) : n_in;
        res_q[k] <= ge ? SQ_RES_W'({2'b00, res_in[SQ_RES_W-1:1]} + BIT)
                       : {1'b0, res_in[SQ_RES_W-1:1]};
      end
    end
  end

  assign root_o = res_q[SQRT_STEPS-1][SQ_OUT_W-1:0];

endmodule

@@ hw/rtl/axr_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Quotient must fit DIV_Q_W bits. Depends on axr_pkg.
`timescale 1ns / 1ps

module axr_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [axr_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [axr_pkg::DIV_DEN_W-1:0] den_i,
  output logic [axr_pkg::DIV_Q_W-1:0]   quo_o
);
  import axr_pkg::*;

  logic [DIV_DEN_W-1:0] rem_q [DIV_STEPS];
  logic [DIV_DEN_W-1:0] den_q [DIV_STEPS];
  logic [DIV_Q_W-1:0]   low_q [DIV_STEPS];
  logic [DIV_Q_W-1:0]   quo_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DIV_DEN_W-1:0] rem_in, den_in;
    logic [DIV_Q_W-1:0]   low_in, quo_in;
    logic [DIV_DEN_W:0]   t, diff;
    logic                 ge;

    if (k == 0) begin : g_first
      // upper numerator bits are below den when the quotient fits
      assign rem_in = DIV_DEN_W'(num_i[DIV_NUM_W-1:DIV_Q_W]);
      assign low_in = num_i[DIV_Q_W-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign t    = {rem_in, low_in[DIV_Q_W-1]};
    assign ge   = t >= {1'b0, den_in};
    assign diff = t - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DIV_DEN_W-1:0] : t[DIV_DEN_W-1:0];
        low_q[k] <= {low_in[DIV_Q_W-2:0], 1'b0};
        quo_q[k] <= {quo_in[DIV_Q_W-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule

@@ hw/rtl/axr_cordic.sv @@
// Pipelined rotation-mode CORDIC giving cos and sin of a Q.30 angle.
// One input register plus one register per micro-rotation. Depends on axr_pkg.
`timescale 1ns / 1ps

module axr_cordic (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [axr_pkg::HW-1:0] angle_i,
  output logic signed [axr_pkg::CW-1:0] cos_o,
  output logic signed [axr_pkg::CW-1:0] sin_o
);
  import axr_pkg::*;

  logic signed [CW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [HW-1:0] z_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CORDIC_GAIN;
      y_q[0] <= '0;
      z_q[0] <= angle_i;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    localparam logic signed [HW-1:0] T = atan_q30(5'(k));
    logic signed [CW-1:0] dx, dy;

    assign dx = y_q[k] >>> k;
    assign dy = x_q[k] >>> k;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[k][HW-1]) begin
          x_q[k+1] <= x_q[k] - dx;
          y_q[k+1] <= y_q[k] + dy;
          z_q[k+1] <= z_q[k] - T;
        end else begin
          x_q[k+1] <= x_q[k] + dx;
          y_q[k+1] <= y_q[k] - dy;
          z_q[k+1] <= z_q[k] + T;
        end
      end
    end
  end

  assign cos_o = x_q[CORDIC_STEPS];
  assign sin_o = y_q[CORDIC_STEPS];

endmodule
